/* src/tgc_pkg.sv */
package tgc_pkg;

  // Field widths
  localparam int POS_W      = 12;
  localparam int TIME_W     = 16;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = 19;
  localparam int DIVIDEND_W = 20;
  localparam int SPEED_W    = 16;
  localparam int TAPS_W     = 2;
  localparam int KIND_W     = 2;
  localparam int GEST_W     = 3;
  localparam int DIR_W      = 2;

  // Stream layout
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Constants
  localparam logic [PROD_W-1:0]  PCT_SCALE = PROD_W'(100);
  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [TAPS_W-1:0]  TAPS_MAX  = {TAPS_W{1'b1}};

  // Register reset values
  localparam logic [PCT_W-1:0]  PCT_RST        = 7'd30;
  localparam logic [TIME_W-1:0] SWIPE_TIME_RST = 16'd500;
  localparam logic [TIME_W-1:0] LONG_TIME_RST  = 16'd2000;
  localparam logic [TIME_W-1:0] DTAP_TIME_RST  = 16'd250;
  localparam logic [POS_W-1:0]  WIDTH_RST      = 12'd1024;
  localparam logic [POS_W-1:0]  HEIGHT_RST     = 12'd768;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_UP   = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE       = 3'd0,
    GEST_SWIPE      = 3'd1,
    GEST_LONG_TAP   = 3'd2,
    GEST_TAP        = 3'd3,
    GEST_DOUBLE_TAP = 3'd4
  } gesture_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    REG_PCT        = 3'd0,
    REG_SWIPE_TIME = 3'd1,
    REG_LONG_TIME  = 3'd2,
    REG_DTAP_TIME  = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_DIV,
    ST_RESULT
  } tgc_state_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* src/tgc_mul.sv */
module tgc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tgc_pkg::PCT_W-1:0]   pct,
  input  logic [tgc_pkg::POS_W-1:0]   ext_w,
  input  logic [tgc_pkg::POS_W-1:0]   ext_h,
  output logic [tgc_pkg::PROD_W-1:0]  prod_w,
  output logic [tgc_pkg::PROD_W-1:0]  prod_h,
  output tgc_pkg::unit_stat_t         stat
);
  import tgc_pkg::*;

  logic [PCT_W-1:0]  mlt_r, mlt_nxt;
  logic [PROD_W-1:0] aw_r, aw_nxt, ah_r, ah_nxt;
  logic [PROD_W-1:0] pw_r, pw_nxt, ph_r, ph_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  // Shift-add: one bit of the percentage per cycle, both extents at once
  always_comb begin
    mlt_nxt  = mlt_r;
    aw_nxt   = aw_r;
    ah_nxt   = ah_r;
    pw_nxt   = pw_r;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mlt_nxt  = pct;
      aw_nxt   = PROD_W'(ext_w);
      ah_nxt   = PROD_W'(ext_h);
      pw_nxt   = '0;
      ph_nxt   = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mlt_r[0]) begin
        pw_nxt = pw_r + aw_r;
        ph_nxt = ph_r + ah_r;
      end
      mlt_nxt = mlt_r >> 1;
      aw_nxt  = aw_r << 1;
      ah_nxt  = ah_r << 1;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'(PCT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mlt_r <= mlt_nxt;
    aw_r  <= aw_nxt;
    ah_r  <= ah_nxt;
    pw_r  <= pw_nxt;
    ph_r  <= ph_nxt;
  end

  assign prod_w    = pw_r;
  assign prod_h    = ph_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* src/tgc_div.sv */
module tgc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tgc_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [tgc_pkg::TIME_W-1:0]      divisor,
  output logic [tgc_pkg::DIVIDEND_W-1:0]  quotient,
  output tgc_pkg::unit_stat_t             stat
);
  import tgc_pkg::*;

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [TIME_W-1:0]     rem_r, rem_nxt;
  logic [TIME_W-1:0]     dvs_r, dvs_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt, done_r, done_nxt;
  logic [TIME_W:0]       trial;
  logic                  ge;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? TIME_W'(trial - {1'b0, dvs_r}) : trial[TIME_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* src/touch_gesture_classifier.sv */
// Touch gesture classifier. Each input transfer (kind in in_tuser: down, move,
// up or a one-millisecond tick, position in in_tdata) yields exactly one result
// transfer: gesture code in out_tuser (none, swipe, long tap, tap, double tap)
// with direction, distance, Q8.8 speed and the release position in out_tdata.
// Down, move and tick events go from idle to the result state, then to the output
// register; an up event passes through the multiply and decide states, a swipe also
// through the divide state. Threshold products come from a bit-serial multiplier (one
// percentage bit per cycle), the speed from a restoring divider (one quotient bit per
// cycle). One event is in flight at a time; a finished result waits in the output
// register while the next event is taken. The user must write registers over the APB
// port only while no event is in flight; the block itself does not enforce this.
module touch_gesture_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tgc_pkg::IN_DATA_W-1:0]     in_tdata,  // pos_x[11:0], pos_y[23:12]
  input  logic [tgc_pkg::KIND_W-1:0]        in_tuser,  // kind[1:0]
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tgc_pkg::OUT_DATA_W-1:0]    out_tdata, // direction[1:0], distance[13:2],
                                                       // speed[29:14], where_x[41:30],
                                                       // where_y[53:42], zero[55:54]
  output logic [tgc_pkg::GEST_W-1:0]        out_tuser, // gesture[2:0]
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tgc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import tgc_pkg::*;

  // Configuration registers
  logic [PCT_W-1:0]  pct_r;
  logic [TIME_W-1:0] swipe_time_r, long_time_r, dtap_time_r;
  logic [POS_W-1:0]  width_r, height_r;
  logic              cfg_wr;

  // Gesture state
  logic [TIME_W-1:0] press_elapsed_r, press_elapsed_nxt;
  logic [POS_W-1:0]  start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [POS_W-1:0]  release_x_r, release_x_nxt, release_y_r, release_y_nxt;
  logic              moved_r, moved_nxt;
  logic [TAPS_W-1:0] tap_count_r, tap_count_nxt;
  logic [TIME_W-1:0] tap_wait_r, tap_wait_nxt;
  logic              armed_r, armed_nxt;

  // Release working values
  logic [POS_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt;
  logic              xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic              fast_r, fast_nxt, long_r, long_nxt;

  // Pending result
  logic [GEST_W-1:0]  res_gest_r, res_gest_nxt;
  logic [DIR_W-1:0]   res_dir_r, res_dir_nxt;
  logic [POS_W-1:0]   res_dist_r, res_dist_nxt;
  logic [SPEED_W-1:0] res_speed_r, res_speed_nxt;
  logic [POS_W-1:0]   res_wx_r, res_wx_nxt, res_wy_r, res_wy_nxt;

  // Output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [GEST_W-1:0]     out_tuser_r;

  tgc_state_t state_r, state_nxt;

  logic                  in_fire, out_free, out_load;
  logic                  mul_start, div_start;
  logic [POS_W-1:0]      in_x, in_y;
  kind_t                 in_kind;
  logic [PROD_W-1:0]     prod_w, prod_h, ax100, ay100;
  logic                  swipe_x, swipe_y;
  logic [TIME_W-1:0]     pe_inc, tw_inc, div_time;
  logic [DIVIDEND_W-1:0] dividend, quotient;
  unit_stat_t            mul_stat, div_stat;

  assign in_x    = in_tdata[POS_W-1:0];
  assign in_y    = in_tdata[2*POS_W-1:POS_W];
  assign in_kind = kind_t'(in_tuser);
  assign in_fire = in_tvalid && in_tready;

  // APB register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r        <= PCT_RST;
      swipe_time_r <= SWIPE_TIME_RST;
      long_time_r  <= LONG_TIME_RST;
      dtap_time_r  <= DTAP_TIME_RST;
      width_r      <= WIDTH_RST;
      height_r     <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_PCT:        pct_r        <= cfg_pwdata[PCT_W-1:0];
        REG_SWIPE_TIME: swipe_time_r <= cfg_pwdata[TIME_W-1:0];
        REG_LONG_TIME:  long_time_r  <= cfg_pwdata[TIME_W-1:0];
        REG_DTAP_TIME:  dtap_time_r  <= cfg_pwdata[TIME_W-1:0];
        REG_WIDTH:      width_r      <= cfg_pwdata[POS_W-1:0];
        REG_HEIGHT:     height_r     <= cfg_pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_PCT:        cfg_prdata = CFG_DATA_W'(pct_r);
      REG_SWIPE_TIME: cfg_prdata = CFG_DATA_W'(swipe_time_r);
      REG_LONG_TIME:  cfg_prdata = CFG_DATA_W'(long_time_r);
      REG_DTAP_TIME:  cfg_prdata = CFG_DATA_W'(dtap_time_r);
      REG_WIDTH:      cfg_prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT:     cfg_prdata = CFG_DATA_W'(height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Serial arithmetic units
  tgc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .pct    (pct_r),
    .ext_w  (width_r),
    .ext_h  (height_r),
    .prod_w (prod_w),
    .prod_h (prod_h),
    .stat   (mul_stat)
  );

  assign div_time = (press_elapsed_r == '0) ? TIME_W'(1) : press_elapsed_r;
  assign dividend = swipe_x ? {ax_r, 8'd0} : {ay_r, 8'd0};

  tgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (div_time),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Release classification
  assign ax100   = PROD_W'(ax_r) * PCT_SCALE;
  assign ay100   = PROD_W'(ay_r) * PCT_SCALE;
  assign swipe_x = (ax_r > ay_r) && (ax100 > prod_w) && fast_r;
  assign swipe_y = (ax_r < ay_r) && (ay100 > prod_h) && fast_r;

  assign pe_inc = (press_elapsed_r == TIME_MAX) ? TIME_MAX : press_elapsed_r + 16'd1;
  assign tw_inc = (tap_wait_r == TIME_MAX) ? TIME_MAX : tap_wait_r + 16'd1;

  assign out_free = !out_tvalid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_kind == KIND_UP) ? ST_MUL : ST_RESULT;
      end
      ST_MUL: begin
        if (mul_stat.done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = (swipe_x || swipe_y) ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mul_start = in_tvalid && (in_kind == KIND_UP);
      end
      ST_DECIDE: div_start = swipe_x || swipe_y;
      ST_RESULT: out_load  = out_free;
      default: ;
    endcase
  end

  // Gesture state and pending result
  always_comb begin
    press_elapsed_nxt = press_elapsed_r;
    start_x_nxt       = start_x_r;
    start_y_nxt       = start_y_r;
    release_x_nxt     = release_x_r;
    release_y_nxt     = release_y_r;
    moved_nxt         = moved_r;
    tap_count_nxt     = tap_count_r;
    tap_wait_nxt      = tap_wait_r;
    armed_nxt         = armed_r;
    ax_nxt            = ax_r;
    ay_nxt            = ay_r;
    xneg_nxt          = xneg_r;
    yneg_nxt          = yneg_r;
    fast_nxt          = fast_r;
    long_nxt          = long_r;
    res_gest_nxt      = res_gest_r;
    res_dir_nxt       = res_dir_r;
    res_dist_nxt      = res_dist_r;
    res_speed_nxt     = res_speed_r;
    res_wx_nxt        = res_wx_r;
    res_wy_nxt        = res_wy_r;

    if (state_r == ST_IDLE && in_fire) begin
      res_gest_nxt  = GEST_NONE;
      res_dir_nxt   = DIR_LEFT;
      res_dist_nxt  = '0;
      res_speed_nxt = '0;
      res_wx_nxt    = '0;
      res_wy_nxt    = '0;
      case (in_kind)
        KIND_DOWN: begin
          moved_nxt         = 1'b0;
          press_elapsed_nxt = '0;
          start_x_nxt       = in_x;
          start_y_nxt       = in_y;
        end
        KIND_MOVE: moved_nxt = 1'b1;
        KIND_UP: begin
          // Capture deltas and timing tests; products follow serially
          release_x_nxt = in_x;
          release_y_nxt = in_y;
          xneg_nxt      = start_x_r < in_x;
          yneg_nxt      = start_y_r < in_y;
          ax_nxt        = (start_x_r < in_x) ? in_x - start_x_r : start_x_r - in_x;
          ay_nxt        = (start_y_r < in_y) ? in_y - start_y_r : start_y_r - in_y;
          fast_nxt      = press_elapsed_r < swipe_time_r;
          long_nxt      = press_elapsed_r >= long_time_r;
        end
        KIND_TICK: begin
          press_elapsed_nxt = pe_inc;
          if (armed_r) begin
            tap_wait_nxt = tw_inc;
            // Window over: settle single or double tap
            if (tw_inc >= dtap_time_r) begin
              armed_nxt     = 1'b0;
              tap_count_nxt = '0;
              if (tap_count_r == TAPS_W'(1) && !moved_r) begin
                res_gest_nxt = GEST_TAP;
                res_wx_nxt   = release_x_r;
                res_wy_nxt   = release_y_r;
              end else if (tap_count_r == TAPS_W'(2)) begin
                res_gest_nxt = GEST_DOUBLE_TAP;
                res_wx_nxt   = release_x_r;
                res_wy_nxt   = release_y_r;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (state_r == ST_DECIDE) begin
      if (swipe_x) begin
        res_gest_nxt = GEST_SWIPE;
        res_dir_nxt  = xneg_r ? DIR_LEFT : DIR_RIGHT;
        res_dist_nxt = ax_r;
      end else if (swipe_y) begin
        res_gest_nxt = GEST_SWIPE;
        res_dir_nxt  = yneg_r ? DIR_DOWN : DIR_UP;
        res_dist_nxt = ay_r;
      end else if (long_r) begin
        res_gest_nxt = GEST_LONG_TAP;
        res_wx_nxt   = release_x_r;
        res_wy_nxt   = release_y_r;
      end else begin
        // Short press: count a tap, arm the window on the first one
        if (tap_count_r == '0) begin
          tap_wait_nxt = '0;
          armed_nxt    = 1'b1;
        end
        if (tap_count_r != TAPS_MAX) tap_count_nxt = tap_count_r + TAPS_W'(1);
      end
    end

    // Saturate the Q8.8 speed
    if (state_r == ST_DIV && div_stat.done) begin
      res_speed_nxt = (|quotient[DIVIDEND_W-1:SPEED_W]) ? SPEED_MAX : quotient[SPEED_W-1:0];
    end
  end

  // Output register handshake
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load)        out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_tvalid_r    <= 1'b0;
      press_elapsed_r <= '0;
      start_x_r       <= '0;
      start_y_r       <= '0;
      release_x_r     <= '0;
      release_y_r     <= '0;
      moved_r         <= 1'b0;
      tap_count_r     <= '0;
      tap_wait_r      <= '0;
      armed_r         <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
      press_elapsed_r <= press_elapsed_nxt;
      start_x_r       <= start_x_nxt;
      start_y_r       <= start_y_nxt;
      release_x_r     <= release_x_nxt;
      release_y_r     <= release_y_nxt;
      moved_r         <= moved_nxt;
      tap_count_r     <= tap_count_nxt;
      tap_wait_r      <= tap_wait_nxt;
      armed_r         <= armed_nxt;
    end
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    xneg_r      <= xneg_nxt;
    yneg_r      <= yneg_nxt;
    fast_r      <= fast_nxt;
    long_r      <= long_nxt;
    res_gest_r  <= res_gest_nxt;
    res_dir_r   <= res_dir_nxt;
    res_dist_r  <= res_dist_nxt;
    res_speed_r <= res_speed_nxt;
    res_wx_r    <= res_wx_nxt;
    res_wy_r    <= res_wy_nxt;
    if (out_load) begin
      out_tuser_r <= res_gest_r;
      out_tdata_r <= OUT_DATA_W'({res_wy_r, res_wx_r, res_speed_r, res_dist_r, res_dir_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The multiplier only runs while a release waits on it
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.busy |-> state_r == ST_MUL)
    else $error("multiplier busy outside multiply state");

  // The divider only runs for a swipe
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV && res_gest_r == GEST_SWIPE)
    else $error("divider busy outside swipe division");

  // Tap window is armed exactly while taps are counted
  a_tap_armed: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r == (tap_count_r != '0))
    else $error("tap window and tap count disagree");

  // Only swipes carry speed
  a_speed_swipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r != GEST_SWIPE |-> out_tdata_r[29:14] == '0)
    else $error("speed reported on a non-swipe result");

endmodule
